/* rtl/llqm_pkg.sv */
// ----------------------------------------------------------------------------
// llqm_pkg: shared types for the linked list queue manager
// Operation codes, controller states and the command/status structs.
// ----------------------------------------------------------------------------
package llqm_pkg;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_PREPEND = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_SHIFT   = 3'd3,
        OP_POP     = 3'd4,
        OP_SPLICE  = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_QUERY   = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_FETCH,
        ST_OUT
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;   // latch the input item
        logic read;      // issue link reads for the target element
        logic exec;      // apply the operation
        logic fetch;     // read the links of the given element
        logic load_out;  // load the output register
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic out_busy;  // output register holds an item not yet taken
    } t_status;

endpackage

/* rtl/llqm_if.sv */
// ----------------------------------------------------------------------------
// llqm_stream_if: valid/ready channel
// Carries one item of a payload of parameter width between a source and a sink.
// ----------------------------------------------------------------------------
interface llqm_stream_if #(parameter int WIDTH = 8);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/llqm_ctrl.sv */
// ----------------------------------------------------------------------------
// llqm_ctrl: operation sequencer
// Steps each item through capture, link read, update, result read and output.
// ----------------------------------------------------------------------------
module llqm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  llqm_pkg::t_status  i_status,
    output llqm_pkg::t_cmd     o_cmd
);
    llqm_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= llqm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            llqm_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = llqm_pkg::ST_READ;
                end
            end
            llqm_pkg::ST_READ: begin
                o_cmd.read = 1'b1;
                n_state = llqm_pkg::ST_EXEC;
            end
            llqm_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state = llqm_pkg::ST_FETCH;
            end
            llqm_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = llqm_pkg::ST_OUT;
            end
            llqm_pkg::ST_OUT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = llqm_pkg::ST_IDLE;
                end
            end
            default: n_state = llqm_pkg::ST_IDLE;
        endcase
    end
endmodule

/* rtl/llqm_datapath.sv */
// ----------------------------------------------------------------------------
// llqm_datapath: list state, link memories and output register
// Holds head, tail and count per list and the next/prev link memories.
// ----------------------------------------------------------------------------
module llqm_datapath #(
    parameter int POOL_ENTRIES = 256,
    parameter int NUM_LISTS    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  llqm_pkg::t_cmd    i_cmd,
    output llqm_pkg::t_status o_status,
    input  logic [2:0]        i_mode,
    input  logic [1:0]        i_list_id,
    input  logic [1:0]        i_source_list_id,
    input  logic [7:0]        i_element,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [8:0]        o_taken_element,
    output logic [8:0]        o_list_head,
    output logic [8:0]        o_list_tail,
    output logic [8:0]        o_list_count,
    output logic [8:0]        o_next_link,
    output logic [8:0]        o_prev_link,
    output logic              o_is_empty
);
    localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
    localparam logic [8:0] NONE = 9'(POOL_ENTRIES);

    logic [8:0] r_next_mem [POOL_ENTRIES];
    logic [8:0] r_prev_mem [POOL_ENTRIES];
    logic [8:0] r_head [NUM_LISTS];
    logic [8:0] r_tail [NUM_LISTS];
    logic [8:0] r_count [NUM_LISTS];

    logic [2:0]    r_mode;
    logic [LW-1:0] r_l, r_s;
    logic [8:0]    r_e;       // element given by the item
    logic [8:0]    r_tgt;     // element removed (given, head or tail)
    logic [8:0]    r_rd_next, r_rd_prev;
    logic          r_out_valid;

    function automatic logic inp(input logic [8:0] v);
        return 32'(v) < POOL_ENTRIES;
    endfunction

    // A list selector wraps into the number of lists by repeated subtraction.
    function automatic logic [LW-1:0] list_wrap(input logic [1:0] v);
        logic [7:0] x;
        x = 8'(v);
        for (int k = 0; k < 4; k++) begin
            if (32'(x) >= NUM_LISTS) x = x - 8'(NUM_LISTS);
        end
        return LW'(x);
    endfunction

    always_comb o_status.out_busy = r_out_valid && !i_out_ready;

    // Target of a remove-like operation, chosen after capture.
    logic [8:0] w_tgt;
    always_comb begin
        case (r_mode)
            llqm_pkg::OP_SHIFT: w_tgt = r_head[r_l];
            llqm_pkg::OP_POP:   w_tgt = r_tail[r_l];
            default:            w_tgt = r_e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_l    <= list_wrap(i_list_id);
            r_s    <= list_wrap(i_source_list_id);
            r_e    <= {1'b0, i_element};
        end
        if (i_cmd.read) begin
            r_tgt     <= w_tgt;
            r_rd_next <= r_next_mem[w_tgt[AW-1:0]];
            r_rd_prev <= r_prev_mem[w_tgt[AW-1:0]];
        end
        if (i_cmd.fetch) begin
            r_rd_next <= r_next_mem[r_e[AW-1:0]];
            r_rd_prev <= r_prev_mem[r_e[AW-1:0]];
        end
    end

    // Link memory writes and list state updates; up to two entries per memory.
    logic       we_n0, we_n1, we_p0, we_p1;
    logic [8:0] wa_n0, wa_n1, wa_p0, wa_p1, wd_n0, wd_n1, wd_p0, wd_p1;
    logic [8:0] p_l, n_l, sh, dt;
    logic       rm_go;

    always_comb begin
        we_n0 = 1'b0; we_n1 = 1'b0; we_p0 = 1'b0; we_p1 = 1'b0;
        wa_n0 = r_e; wa_n1 = r_e; wa_p0 = r_e; wa_p1 = r_e;
        wd_n0 = NONE; wd_n1 = NONE; wd_p0 = NONE; wd_p1 = NONE;
        p_l = inp(r_rd_prev) ? r_rd_prev : NONE;
        n_l = inp(r_rd_next) ? r_rd_next : NONE;
        sh = r_head[r_s];
        dt = r_tail[r_l];
        rm_go = 1'b0;
        case (r_mode)
            llqm_pkg::OP_APPEND: if (inp(r_e)) begin
                we_n0 = 1'b1;
                we_p0 = 1'b1; wd_p0 = inp(r_tail[r_l]) ? r_tail[r_l] : NONE;
                we_n1 = inp(r_tail[r_l]); wa_n1 = r_tail[r_l]; wd_n1 = r_e;
            end
            llqm_pkg::OP_PREPEND: if (inp(r_e)) begin
                we_p0 = 1'b1;
                we_n0 = 1'b1; wd_n0 = inp(r_head[r_l]) ? r_head[r_l] : NONE;
                we_p1 = inp(r_head[r_l]); wa_p1 = r_head[r_l]; wd_p1 = r_e;
            end
            llqm_pkg::OP_REMOVE, llqm_pkg::OP_SHIFT, llqm_pkg::OP_POP: begin
                rm_go = inp(r_tgt);
                if (rm_go) begin
                    // Neighbor writes first, own clears last so they win.
                    we_n1 = inp(p_l); wa_n1 = p_l; wd_n1 = n_l;
                    we_p1 = inp(n_l); wa_p1 = n_l; wd_p1 = p_l;
                    we_n0 = 1'b1; wa_n0 = r_tgt;
                    we_p0 = 1'b1; wa_p0 = r_tgt;
                end
            end
            llqm_pkg::OP_SPLICE: if (r_l != r_s && r_count[r_s] != 9'd0) begin
                we_p0 = inp(sh); wa_p0 = sh; wd_p0 = inp(dt) ? dt : NONE;
                we_n0 = inp(dt); wa_n0 = dt; wd_n0 = inp(sh) ? sh : NONE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_n1) r_next_mem[wa_n1[AW-1:0]] <= wd_n1;
            if (we_n0) r_next_mem[wa_n0[AW-1:0]] <= wd_n0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (we_p1) r_prev_mem[wa_p1[AW-1:0]] <= wd_p1;
            if (we_p0) r_prev_mem[wa_p0[AW-1:0]] <= wd_p0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LISTS; i++) begin
                r_head[i]  <= NONE;
                r_tail[i]  <= NONE;
                r_count[i] <= 9'd0;
            end
        end else if (i_cmd.exec) begin
            case (r_mode)
                llqm_pkg::OP_APPEND: if (inp(r_e)) begin
                    if (!inp(r_head[r_l])) r_head[r_l] <= r_e;
                    r_tail[r_l]  <= r_e;
                    r_count[r_l] <= r_count[r_l] + 9'd1;
                end
                llqm_pkg::OP_PREPEND: if (inp(r_e)) begin
                    if (!inp(r_tail[r_l])) r_tail[r_l] <= r_e;
                    r_head[r_l]  <= r_e;
                    r_count[r_l] <= r_count[r_l] + 9'd1;
                end
                llqm_pkg::OP_REMOVE, llqm_pkg::OP_SHIFT, llqm_pkg::OP_POP: if (rm_go) begin
                    if (r_head[r_l] == r_tgt) r_head[r_l] <= n_l;
                    if (r_tail[r_l] == r_tgt) r_tail[r_l] <= p_l;
                    r_count[r_l] <= r_count[r_l] - 9'd1;
                end
                llqm_pkg::OP_SPLICE: if (r_l != r_s && r_count[r_s] != 9'd0) begin
                    if (!inp(r_head[r_l])) r_head[r_l] <= sh;
                    r_tail[r_l]  <= r_tail[r_s];
                    r_count[r_l] <= r_count[r_l] + r_count[r_s];
                    r_count[r_s] <= 9'd0;
                    r_head[r_s]  <= NONE;
                    r_tail[r_s]  <= NONE;
                end
                llqm_pkg::OP_CLEAR: begin
                    r_head[r_l]  <= NONE;
                    r_tail[r_l]  <= NONE;
                    r_count[r_l] <= 9'd0;
                end
                default: ;
            endcase
        end
    end

    // Taken element is decided in exec; hold it for the output.
    logic [8:0] r_taken;
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_taken <= ((r_mode == llqm_pkg::OP_SHIFT || r_mode == llqm_pkg::OP_POP)
                        && rm_go) ? r_tgt : NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_taken_element <= r_taken;
            o_list_head     <= r_head[r_l];
            o_list_tail     <= r_tail[r_l];
            o_list_count    <= r_count[r_l];
            o_is_empty      <= (r_count[r_l] == 9'd0);
            o_next_link     <= inp(r_e) ? r_rd_next : NONE;
            o_prev_link     <= inp(r_e) ? r_rd_prev : NONE;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

/* rtl/linked_list_queue_manager.sv */
// ----------------------------------------------------------------------------
// linked_list_queue_manager: doubly linked lists over a shared element pool
// Append, prepend, remove, shift, pop, splice, clear and query per item.
// ----------------------------------------------------------------------------
// Each accepted item steps through capture, link read, link update, result read
// and output load; the load waits while an untaken result holds the output, and
// no new item is taken until the controller is back in idle.
// Reset: synchronous, active low; lists become empty, link memories keep data.
// ----------------------------------------------------------------------------
module linked_list_queue_manager #(
    parameter int POOL_ENTRIES = 256,
    parameter int NUM_LISTS    = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    llqm_stream_if.sink   i_in,
    llqm_stream_if.source o_out
);
    // Input item layout: {mode, list_id, source_list_id, element}.
    // Result item layout: {taken, head, tail, count, next, prev, is_empty}.
    llqm_pkg::t_cmd    w_cmd;
    llqm_pkg::t_status w_status;
    logic [8:0] w_taken, w_head, w_tail, w_count, w_next, w_prev;
    logic       w_empty;

    llqm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    llqm_datapath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .NUM_LISTS    (NUM_LISTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_mode           (i_in.data[14:12]),
        .i_list_id        (i_in.data[11:10]),
        .i_source_list_id (i_in.data[9:8]),
        .i_element        (i_in.data[7:0]),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .o_taken_element  (w_taken),
        .o_list_head      (w_head),
        .o_list_tail      (w_tail),
        .o_list_count     (w_count),
        .o_next_link      (w_next),
        .o_prev_link      (w_prev),
        .o_is_empty       (w_empty)
    );

    assign o_out.data = {w_taken, w_head, w_tail, w_count, w_next, w_prev, w_empty};
endmodule

/* rtl/llqm_checker.sv */
// ----------------------------------------------------------------------------
// llqm_checker: port-level assertions
// Checks result consistency and item spacing at the top level ports.
// ----------------------------------------------------------------------------
module llqm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [54:0] i_out_data
);
    // The empty flag agrees with the count.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data[0] == (i_out_data[27:19] == 9'd0)))
        else $error("empty flag disagrees with count");

    // An empty list has neither a head nor a tail.
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data[0]) |-> (i_out_data[45:37] == 9'd256 &&
            i_out_data[36:28] == 9'd256))
        else $error("empty list shows a head or tail");

    // No new item is taken right after one was accepted.
    a_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("item accepted back to back");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");
endmodule

bind linked_list_queue_manager llqm_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

/* test/tb_llqm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_llqm_checker: list state predictor and result scoreboard
// Watches both channels, keeps its own copy of the link tables and per-list
// head, tail and count, and compares each result item field by field.
// ----------------------------------------------------------------------------
module tb_llqm_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    llqm_stream_if in_mon,
    llqm_stream_if out_mon,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked
);
    localparam logic [8:0] NO_ELEM = 9'd256;

    typedef struct packed {
        logic [8:0] taken;
        logic [8:0] head;
        logic [8:0] tail;
        logic [8:0] count;
        logic [8:0] nxt;
        logic [8:0] prv;
        logic       empty;
    } t_list_result;

    logic [8:0] next_links [256];
    logic [8:0] prev_links [256];
    logic [8:0] heads [4];
    logic [8:0] tails [4];
    logic [8:0] counts [4];

    t_list_result expected_results [$];

    function automatic bit in_pool(logic [8:0] x);
        return !x[8];
    endfunction

    task automatic unlink(int l, logic [8:0] e);
        logic [8:0] p;
        logic [8:0] n;
        p = prev_links[e[7:0]];
        n = next_links[e[7:0]];
        if (!in_pool(p)) p = NO_ELEM;
        if (!in_pool(n)) n = NO_ELEM;
        if (heads[l] == e) heads[l] = n;
        if (tails[l] == e) tails[l] = p;
        if (in_pool(p)) next_links[p[7:0]] = n;
        if (in_pool(n)) prev_links[n[7:0]] = p;
        counts[l] = counts[l] - 9'd1;
        prev_links[e[7:0]] = NO_ELEM;
        next_links[e[7:0]] = NO_ELEM;
    endtask

    // Applies one command to the predicted state and returns its result.
    task automatic predict_list_op(logic [14:0] cmd, output t_list_result r);
        llqm_pkg::t_op op;
        int            l;
        int            s;
        logic [8:0]    e;
        logic [8:0]    x;
        op = llqm_pkg::t_op'(cmd[14:12]);
        l  = cmd[11:10];
        s  = cmd[9:8];
        e  = {1'b0, cmd[7:0]};
        r.taken = NO_ELEM;
        case (op)
            llqm_pkg::OP_APPEND: begin
                if (!in_pool(heads[l])) heads[l] = e;
                if (in_pool(tails[l])) begin
                    prev_links[e[7:0]] = tails[l];
                    next_links[tails[l][7:0]] = e;
                end else begin
                    prev_links[e[7:0]] = NO_ELEM;
                end
                tails[l] = e;
                next_links[e[7:0]] = NO_ELEM;
                counts[l] = counts[l] + 9'd1;
            end
            llqm_pkg::OP_PREPEND: begin
                if (!in_pool(tails[l])) tails[l] = e;
                if (in_pool(heads[l])) begin
                    next_links[e[7:0]] = heads[l];
                    prev_links[heads[l][7:0]] = e;
                end else begin
                    next_links[e[7:0]] = NO_ELEM;
                end
                heads[l] = e;
                prev_links[e[7:0]] = NO_ELEM;
                counts[l] = counts[l] + 9'd1;
            end
            llqm_pkg::OP_REMOVE: unlink(l, e);
            llqm_pkg::OP_SHIFT: begin
                x = heads[l];
                if (in_pool(x)) begin
                    unlink(l, x);
                    r.taken = x;
                end
            end
            llqm_pkg::OP_POP: begin
                x = tails[l];
                if (in_pool(x)) begin
                    unlink(l, x);
                    r.taken = x;
                end
            end
            llqm_pkg::OP_SPLICE: begin
                if (l != s && counts[s] != 9'd0) begin
                    if (in_pool(heads[s]))
                        prev_links[heads[s][7:0]] = in_pool(tails[l]) ? tails[l] : NO_ELEM;
                    if (in_pool(tails[l]))
                        next_links[tails[l][7:0]] = in_pool(heads[s]) ? heads[s] : NO_ELEM;
                    if (!in_pool(heads[l])) heads[l] = heads[s];
                    tails[l]  = tails[s];
                    counts[l] = counts[l] + counts[s];
                    counts[s] = 9'd0;
                    heads[s]  = NO_ELEM;
                    tails[s]  = NO_ELEM;
                end
            end
            llqm_pkg::OP_CLEAR: begin
                heads[l]  = NO_ELEM;
                tails[l]  = NO_ELEM;
                counts[l] = 9'd0;
            end
            default: ;
        endcase
        r.head  = heads[l];
        r.tail  = tails[l];
        r.count = counts[l];
        r.nxt   = next_links[e[7:0]];
        r.prv   = prev_links[e[7:0]];
        r.empty = (counts[l] == 9'd0);
    endtask

    function automatic logic [8:0] field_of(t_list_result r, int i);
        case (i)
            0: return r.taken;
            1: return r.head;
            2: return r.tail;
            3: return r.count;
            4: return r.nxt;
            5: return r.prv;
            default: return {8'd0, r.empty};
        endcase
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_list_result exp_r;
        t_list_result got_r;
        bit           bad;
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                heads[i]  = NO_ELEM;
                tails[i]  = NO_ELEM;
                counts[i] = 9'd0;
            end
            expected_results.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (in_mon.valid && in_mon.ready) begin
                predict_list_op(in_mon.data, exp_r);
                expected_results.push_back(exp_r);
            end
            if (out_mon.valid && out_mon.ready) begin
                got_r = out_mon.data;
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result item %h", got_r);
                end else begin
                    exp_r = expected_results.pop_front();
                    bad = 0;
                    for (int i = 0; i < 7; i++)
                        if (field_of(exp_r, i) !== field_of(got_r, i)) bad = 1;
                    if (bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"Mismatch at result %0d: expected tk=%0d h=%0d",
                                      " t=%0d c=%0d n=%0d p=%0d e=%0d,"},
                                     o_checked, exp_r.taken, exp_r.head, exp_r.tail,
                                     exp_r.count, exp_r.nxt, exp_r.prv, exp_r.empty);
                            $display("    got tk=%0d h=%0d t=%0d c=%0d n=%0d p=%0d e=%0d",
                                     got_r.taken, got_r.head, got_r.tail, got_r.count,
                                     got_r.nxt, got_r.prv, got_r.empty);
                        end
                    end
                    o_checked++;
                end
            end
        end
    end
endmodule

/* test/tb_linked_list_queue_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linked_list_queue_manager: stimulus and verdict for the list manager
// Drives directed and random list commands that keep membership legal, with
// random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_linked_list_queue_manager;
    localparam int RANDOM_ITEMS = 1430;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int FREE         = 4;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   checked;
    int   cycles = 0;
    int   sent;
    bit   no_idle;

    llqm_stream_if #(.WIDTH(15)) cmd_ch ();
    llqm_stream_if #(.WIDTH(55)) res_ch ();

    linked_list_queue_manager uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch)
    );

    tb_llqm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (cmd_ch),
        .out_mon      (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Shadow of list membership, in order, so that every command we issue is
    // legal: removes name a real member, and no element sits in two lists.
    int list_members [4][$];
    int owner_of [256];
    bit ever_linked [256];
    int linked_total;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The cycle counter guards against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // The result side stalls about 17 percent of cycles, except during the
    // stretch where the sender runs back to back.
    always @(posedge i_clk) begin
        res_ch.ready <= no_idle || ($urandom_range(99) >= 17);
    end

    // Mirror the membership effect of one command, then send it. The
    // predictor in the checker works out the actual expected result.
    task automatic issue(llqm_pkg::t_op op, int l, int s, int e);
        int idx;
        case (op)
            llqm_pkg::OP_APPEND: list_members[l].push_back(e);
            llqm_pkg::OP_PREPEND: list_members[l].push_front(e);
            llqm_pkg::OP_REMOVE: begin
                for (int i = 0; i < list_members[l].size(); i++)
                    if (list_members[l][i] == e) idx = i;
                list_members[l].delete(idx);
            end
            llqm_pkg::OP_SHIFT: if (list_members[l].size() > 0) begin
                owner_of[list_members[l][0]] = FREE;
                void'(list_members[l].pop_front());
            end
            llqm_pkg::OP_POP: if (list_members[l].size() > 0) begin
                owner_of[list_members[l][$]] = FREE;
                void'(list_members[l].pop_back());
            end
            llqm_pkg::OP_SPLICE: if (l != s) begin
                foreach (list_members[s][i]) owner_of[list_members[s][i]] = l;
                list_members[l] = {list_members[l], list_members[s]};
                list_members[s].delete();
            end
            llqm_pkg::OP_CLEAR: begin
                foreach (list_members[l][i]) owner_of[list_members[l][i]] = FREE;
                list_members[l].delete();
            end
            default: ;
        endcase
        if (op == llqm_pkg::OP_APPEND || op == llqm_pkg::OP_PREPEND) begin
            owner_of[e] = l;
            if (!ever_linked[e]) linked_total++;
            ever_linked[e] = 1;
        end
        if (op == llqm_pkg::OP_REMOVE) owner_of[e] = FREE;

        // Random gap before the item, then hold it until it is taken.
        if (!no_idle) begin
            while ($urandom_range(99) < 17) begin
                cmd_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= {op, 2'(l), 2'(s), 8'(e)};
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent++;
    endtask

    // Any element whose links have been written at least once; reading the
    // links of a never-linked element is outside the contract.
    function automatic int pick_linked();
        int e;
        do e = $urandom_range(255); while (!ever_linked[e]);
        return e;
    endfunction

    task automatic random_item();
        int r;
        int l;
        int s;
        int e;
        r = $urandom_range(99);
        l = $urandom_range(3);
        s = $urandom_range(3);
        if (linked_total == 0) r = 0;
        if (r < 40) begin
            // Append or prepend a free element, falling back to a shift.
            e = $urandom_range(255);
            for (int k = 0; k < 256 && owner_of[e] != FREE; k++) e = (e + 1) % 256;
            if (owner_of[e] == FREE)
                issue((r < 22) ? llqm_pkg::OP_APPEND : llqm_pkg::OP_PREPEND, l, s, e);
            else
                issue(llqm_pkg::OP_SHIFT, l, s, pick_linked());
        end else if (r < 56) begin
            // Remove a real member of a nonempty list, so that middles,
            // heads and tails are all unlinked.
            for (int k = 0; k < 4 && list_members[l].size() == 0; k++) l = (l + 1) % 4;
            if (list_members[l].size() == 0)
                issue(llqm_pkg::OP_QUERY, l, s, pick_linked());
            else
                issue(llqm_pkg::OP_REMOVE, l, s,
                      list_members[l][$urandom_range(list_members[l].size() - 1)]);
        end else if (r < 64) begin
            issue(llqm_pkg::OP_SHIFT, l, s, pick_linked());
        end else if (r < 72) begin
            issue(llqm_pkg::OP_POP, l, s, pick_linked());
        end else if (r < 81) begin
            issue(llqm_pkg::OP_SPLICE, l, s, pick_linked());
        end else if (r < 84) begin
            issue(llqm_pkg::OP_CLEAR, l, s, pick_linked());
        end else begin
            issue(llqm_pkg::OP_QUERY, l, s, pick_linked());
        end
    endtask

    initial begin
        sent         = 0;
        no_idle      = 0;
        linked_total = 0;
        for (int i = 0; i < 256; i++) begin
            owner_of[i]    = FREE;
            ever_linked[i] = 0;
        end
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: pool extremes, every operation, and the degenerate
        // cases of empty lists and a list spliced onto itself.
        issue(llqm_pkg::OP_APPEND, 0, 0, 0);
        issue(llqm_pkg::OP_APPEND, 0, 3, 255);
        issue(llqm_pkg::OP_PREPEND, 3, 0, 1);
        issue(llqm_pkg::OP_APPEND, 0, 2, 128);
        issue(llqm_pkg::OP_QUERY, 0, 0, 255);
        issue(llqm_pkg::OP_QUERY, 2, 1, 0);
        issue(llqm_pkg::OP_SPLICE, 3, 0, 128);
        issue(llqm_pkg::OP_SPLICE, 3, 3, 1);
        issue(llqm_pkg::OP_SPLICE, 1, 2, 1);
        issue(llqm_pkg::OP_QUERY, 3, 0, 1);
        issue(llqm_pkg::OP_REMOVE, 3, 0, 255);
        issue(llqm_pkg::OP_SHIFT, 3, 1, 0);
        issue(llqm_pkg::OP_POP, 3, 2, 128);
        issue(llqm_pkg::OP_SHIFT, 2, 1, 0);
        issue(llqm_pkg::OP_POP, 1, 3, 255);
        issue(llqm_pkg::OP_PREPEND, 2, 3, 254);
        issue(llqm_pkg::OP_APPEND, 2, 3, 127);
        issue(llqm_pkg::OP_CLEAR, 2, 1, 254);
        issue(llqm_pkg::OP_QUERY, 2, 0, 254);
        issue(llqm_pkg::OP_SPLICE, 1, 3, 127);
        issue(llqm_pkg::OP_REMOVE, 1, 0, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle = (n >= 600 && n < 800);
            random_item();
        end
        cmd_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d list commands over all eight operations and four lists,", sent);
        $display("and checked %0d result items against the predicted list state.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d failures", fail_count);
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
